@@ rtl/core/srre_pkg.sv @@
// Package for the sample rate ratio estimator: widths, register map, states.
// No dependencies.
`timescale 1ns / 1ps
package srre_pkg;
  localparam int RatioFracBits = 24;
  localparam int CountWidth = 32;
  localparam int RateW = 18;
  localparam int PaddrW = 5;

  localparam logic [2:0] RegWindow = 3'd0;
  localparam logic [2:0] RegTol = 3'd1;
  localparam logic [2:0] RegAbsMin = 3'd2;
  localparam logic [2:0] RegAbsMax = 3'd3;
  localparam logic [2:0] RegAbNum = 3'd4;
  localparam logic [2:0] RegAbDen = 3'd5;
  localparam logic [2:0] RegBaNum = 3'd6;
  localparam logic [2:0] RegBaDen = 3'd7;

  localparam logic [1:0] SrcReset = 2'd0;
  localparam logic [1:0] SrcNominal = 2'd1;
  localparam logic [1:0] SrcMeasured = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_NOM_DIV, ST_MEAS_DIV, ST_GATE,
    ST_TOB_DIV, ST_TOA_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic start_nom;
    logic start_meas;
    logic gate;
    logic start_tob;
    logic start_toa;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic is_reset;
    logic drop;
    logic rebase_nominal;
    logic measure;
    logic div_done;
    logic gate_pass;
    logic ratio_zero;
  } status_t;
endpackage

@@ rtl/core/srre_if.sv @@
// Valid/ready channel interface carrying a packed payload word.
// Depends on nothing.
`timescale 1ns / 1ps
interface srre_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/sample_rate_ratio_estimator_top.sv @@
// Top level of the sample rate ratio estimator: APB registers and channels.
// Depends on srre_pkg, srre_if, srre_ctrl, srre_dp.
`timescale 1ns / 1ps
// One event is handled at a time. A stream reset presents its result word
// after the decide state; a dropped poll frees the input after the decide
// state. A nominal or measured publish takes three passes of the shared
// 65-step divider, so its result word is valid only after the third pass
// ends. The result word then waits in an output register until taken.
module sample_rate_ratio_estimator_top #(
  parameter int RATIO_FRAC_BITS = srre_pkg::RatioFracBits,
  parameter int COUNT_WIDTH = srre_pkg::CountWidth
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [srre_pkg::PaddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  srre_if.sink   in_ch,
  srre_if.source out_ch
);
  srre_pkg::cmd_t cmd;
  srre_pkg::status_t sts;
  logic [31:0] ratio_to_b, ratio_to_a;
  logic [1:0] ratio_source;

  assign pready = 1'b1;

  srre_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .sts(sts)
  );

  srre_dp #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(psel && penable && pwrite && pready && paddr[1:0] == 2'd0),
    .cfg_idx(paddr[4:2]), .cfg_data(pwdata), .cfg_rd(prdata), .rd_idx(paddr[4:2]),
    .opcode(in_ch.data[0]), .now_ms(in_ch.data[32:1]),
    .snapshot_valid(in_ch.data[33]), .epoch(in_ch.data[65:34]),
    .running_a(in_ch.data[66]), .running_b(in_ch.data[67]),
    .leg_a_rate_hz(in_ch.data[85:68]), .leg_b_rate_hz(in_ch.data[103:86]),
    .blocks_a(in_ch.data[135:104]), .blocks_b(in_ch.data[167:136]),
    .ratio_to_b(ratio_to_b), .ratio_to_a(ratio_to_a), .ratio_source(ratio_source)
  );

  assign out_ch.data = {ratio_source, ratio_to_a, ratio_to_b};
endmodule

@@ rtl/core/srre_div.sv @@
// Restoring divider, one quotient bit per cycle, rounds half up, saturates.
// Depends on nothing.
`timescale 1ns / 1ps
module srre_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [64:0] n;
  logic [64:0] rem;
  logic [64:0] q;
  logic [63:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic        nz;
  logic [65:0] trial;

  assign trial = {rem, n[64]} - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd65;
      end else if (busy) begin
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
    if (start) begin
      n <= {1'b0, num} + {2'b0, den[63:1]};
      d <= den;
      rem <= '0;
      q <= '0;
      nz <= (num != 64'd0);
    end else if (busy && cnt != 7'd0) begin
      n <= {n[63:0], 1'b0};
      if (!trial[65]) begin
        rem <= trial[64:0];
        q <= {q[63:0], 1'b1};
      end else begin
        rem <= {rem[63:0], n[64]};
        q <= {q[63:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (d == 64'd0) quo = 32'hFFFF_FFFF;
    else if (q[64:32] != 33'd0) quo = 32'hFFFF_FFFF;
    else if (q[31:0] == 32'd0 && nz) quo = 32'd1;
    else quo = q[31:0];
  end
endmodule

@@ rtl/core/srre_ctrl.sv @@
// Controller state machine: sequences the datapath for one event.
// Depends on srre_pkg.
`timescale 1ns / 1ps
module srre_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output srre_pkg::cmd_t     cmd,
  input  srre_pkg::status_t  sts
);
  srre_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= srre_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srre_pkg::ST_IDLE: if (in_valid) state_next = srre_pkg::ST_DECIDE;
      srre_pkg::ST_DECIDE: begin
        priority if (sts.is_reset) state_next = srre_pkg::ST_OUT;
        else if (sts.rebase_nominal) state_next = srre_pkg::ST_NOM_DIV;
        else if (sts.measure) state_next = srre_pkg::ST_MEAS_DIV;
        else state_next = srre_pkg::ST_IDLE;
      end
      srre_pkg::ST_NOM_DIV: if (sts.div_done) state_next = srre_pkg::ST_TOB_DIV;
      srre_pkg::ST_MEAS_DIV: if (sts.div_done) state_next = srre_pkg::ST_GATE;
      srre_pkg::ST_GATE:
        state_next = sts.gate_pass ? srre_pkg::ST_TOB_DIV : srre_pkg::ST_IDLE;
      srre_pkg::ST_TOB_DIV: if (sts.div_done) state_next = srre_pkg::ST_TOA_DIV;
      srre_pkg::ST_TOA_DIV: if (sts.div_done) state_next = srre_pkg::ST_OUT;
      srre_pkg::ST_OUT: if (out_ready) state_next = srre_pkg::ST_IDLE;
      default: state_next = srre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == srre_pkg::ST_IDLE);
    out_valid = (state == srre_pkg::ST_OUT);
    cmd.load = in_valid && in_ready;
    cmd.decide = (state == srre_pkg::ST_DECIDE);
    cmd.start_nom = cmd.decide && !sts.is_reset && sts.rebase_nominal;
    cmd.start_meas = cmd.decide && !sts.is_reset && !sts.rebase_nominal && sts.measure;
    cmd.gate = (state == srre_pkg::ST_GATE);
    cmd.start_tob = (state == srre_pkg::ST_NOM_DIV && sts.div_done)
                 || (cmd.gate && sts.gate_pass);
    cmd.start_toa = (state == srre_pkg::ST_TOB_DIV && sts.div_done);
    cmd.publish = (state == srre_pkg::ST_TOA_DIV && sts.div_done);
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> !in_ready)
    else $error("second accept");
endmodule

@@ rtl/core/srre_dp.sv @@
// Datapath: base state, config registers, shared divider, gate, publish regs.
// Depends on srre_pkg and srre_div.
`timescale 1ns / 1ps
module srre_dp #(
  parameter int RATIO_FRAC_BITS = srre_pkg::RatioFracBits,
  parameter int COUNT_WIDTH = srre_pkg::CountWidth
) (
  input  logic                clk,
  input  logic                rst,
  input  srre_pkg::cmd_t      cmd,
  output srre_pkg::status_t   sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  output logic [31:0]         cfg_rd,
  input  logic [2:0]          rd_idx,
  input  logic                opcode,
  input  logic [31:0]         now_ms,
  input  logic                snapshot_valid,
  input  logic [31:0]         epoch,
  input  logic                running_a,
  input  logic                running_b,
  input  logic [17:0]         leg_a_rate_hz,
  input  logic [17:0]         leg_b_rate_hz,
  input  logic [31:0]         blocks_a,
  input  logic [31:0]         blocks_b,
  output logic [31:0]         ratio_to_b,
  output logic [31:0]         ratio_to_a,
  output logic [1:0]          ratio_source
);
  logic [15:0] window, tol;
  logic [31:0] abs_min, abs_max;
  logic [4:0] ab_num, ab_den, ba_num, ba_den;

  logic base_valid;
  logic [31:0] base_epoch, base_time, last_poll, nominal;
  logic [17:0] base_ra, base_rb;
  logic [COUNT_WIDTH-1:0] base_ba, base_bb;

  logic i_op, i_sv, i_both;
  logic [31:0] i_now, i_epoch;
  logic [17:0] i_ra, i_rb;
  logic [COUNT_WIDTH-1:0] i_ba, i_bb;

  logic [31:0] ratio;
  logic [31:0] r_cur;
  logic [31:0] tob;
  logic [63:0] dnum, dden;
  logic dstart, ddone;
  logic [31:0] dq;
  logic ratio_source_nom;

  logic limited, rebase;
  logic [31:0] dt_poll, dt_base;
  logic [COUNT_WIDTH-1:0] da, db;
  logic [4:0] abn, abd, ban, bad;
  logic [63:0] lo_b, hi_b, scaled;

  assign abn = (ab_num == 5'd0) ? 5'd1 : ab_num;
  assign abd = (ab_den == 5'd0) ? 5'd1 : ab_den;
  assign ban = (ba_num == 5'd0) ? 5'd1 : ba_num;
  assign bad = (ba_den == 5'd0) ? 5'd1 : ba_den;

  assign dt_poll = i_now - last_poll;
  assign dt_base = i_now - base_time;
  assign da = i_ba - base_ba;
  assign db = i_bb - base_bb;
  assign limited = base_valid && (dt_poll < {16'd0, window});
  assign rebase = !i_both || !base_valid || i_epoch != base_epoch
               || i_ra != base_ra || i_rb != base_rb;

  assign sts.is_reset = i_op;
  assign sts.drop = limited || !i_sv;
  assign sts.rebase_nominal = !limited && i_sv && rebase && i_both
                           && i_ra != 18'd0 && i_rb != 18'd0;
  assign sts.measure = !limited && i_sv && !rebase
                    && !(dt_base < {16'd0, window}) && da != '0 && db != '0;
  assign sts.div_done = ddone;
  assign sts.ratio_zero = (ratio == 32'd0);

  assign r_cur = (cmd.start_tob && !cmd.gate) ? dq : ratio;

  assign lo_b = {32'd0, nominal} * {47'd0, 17'h10000 - {1'b0, tol}};
  assign hi_b = {32'd0, nominal} * {47'd0, 17'h10000 + {1'b0, tol}};
  assign scaled = {16'd0, ratio, 16'd0};
  always_comb begin
    if (nominal != 32'd0) sts.gate_pass = !(scaled < lo_b || scaled > hi_b);
    else sts.gate_pass = !(ratio < abs_min || ratio > abs_max);
  end

  assign dstart = cmd.start_nom || cmd.start_meas || cmd.start_tob || cmd.start_toa;
  always_comb begin
    dnum = '0;
    dden = '0;
    priority if (cmd.start_nom) begin
      dnum = {46'd0, i_ra} << RATIO_FRAC_BITS;
      dden = {46'd0, i_rb};
    end else if (cmd.start_meas) begin
      dnum = {{(64-COUNT_WIDTH){1'b0}}, da} << RATIO_FRAC_BITS;
      dden = {{(64-COUNT_WIDTH){1'b0}}, db};
    end else if (cmd.start_tob) begin
      dnum = {32'd0, r_cur} * {59'd0, abn};
      dden = {59'd0, abd};
    end else if (cmd.start_toa) begin
      dnum = {59'd0, ban} << (2 * RATIO_FRAC_BITS);
      dden = {32'd0, ratio} * {59'd0, bad};
    end else begin
      dnum = '0;
    end
  end

  srre_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dq)
  );

  always_comb begin
    unique case (rd_idx)
      srre_pkg::RegWindow: cfg_rd = {16'd0, window};
      srre_pkg::RegTol: cfg_rd = {16'd0, tol};
      srre_pkg::RegAbsMin: cfg_rd = abs_min;
      srre_pkg::RegAbsMax: cfg_rd = abs_max;
      srre_pkg::RegAbNum: cfg_rd = {27'd0, ab_num};
      srre_pkg::RegAbDen: cfg_rd = {27'd0, ab_den};
      srre_pkg::RegBaNum: cfg_rd = {27'd0, ba_num};
      srre_pkg::RegBaDen: cfg_rd = {27'd0, ba_den};
      default: cfg_rd = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= 16'd20;
      tol <= 16'd3932;
      abs_min <= 32'd1290555;
      abs_max <= 32'd218103808;
      ab_num <= 5'd1;
      ab_den <= 5'd1;
      ba_num <= 5'd1;
      ba_den <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        srre_pkg::RegWindow: window <= cfg_data[15:0];
        srre_pkg::RegTol: tol <= cfg_data[15:0];
        srre_pkg::RegAbsMin: abs_min <= cfg_data;
        srre_pkg::RegAbsMax: abs_max <= cfg_data;
        srre_pkg::RegAbNum: ab_num <= cfg_data[4:0];
        srre_pkg::RegAbDen: ab_den <= cfg_data[4:0];
        srre_pkg::RegBaNum: ba_num <= cfg_data[4:0];
        srre_pkg::RegBaDen: ba_den <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_op <= opcode;
      i_sv <= snapshot_valid;
      i_both <= running_a && running_b;
      i_now <= now_ms;
      i_epoch <= epoch;
      i_ra <= leg_a_rate_hz;
      i_rb <= leg_b_rate_hz;
      i_ba <= blocks_a[COUNT_WIDTH-1:0];
      i_bb <= blocks_b[COUNT_WIDTH-1:0];
    end
    if (ddone && !cmd.start_toa && !cmd.publish) ratio <= dq;
    if (cmd.start_toa) tob <= dq;
    if (cmd.decide && i_op) begin
      ratio_to_b <= 32'd0;
      ratio_to_a <= 32'd0;
      ratio_source <= srre_pkg::SrcReset;
    end
    if (cmd.publish) begin
      ratio_to_b <= tob;
      ratio_to_a <= dq;
      ratio_source <= ratio_source_nom ? srre_pkg::SrcNominal : srre_pkg::SrcMeasured;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_nom) ratio_source_nom <= 1'b1;
    else if (cmd.start_meas) ratio_source_nom <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_valid <= 1'b0;
      base_epoch <= '0;
      base_ra <= '0;
      base_rb <= '0;
      base_ba <= '0;
      base_bb <= '0;
      base_time <= '0;
      last_poll <= '0;
      nominal <= '0;
    end else if (cmd.decide) begin
      if (i_op) begin
        base_valid <= 1'b0;
        base_ra <= '0;
        base_rb <= '0;
        nominal <= '0;
      end else if (!limited) begin
        last_poll <= i_now;
        if (i_sv && rebase) begin
          base_epoch <= i_epoch;
          base_ra <= i_ra;
          base_rb <= i_rb;
          base_ba <= i_ba;
          base_bb <= i_bb;
          base_time <= i_now;
          base_valid <= i_both;
          nominal <= '0;
        end
      end
    end else if (cmd.start_tob && ratio_source_nom) begin
      nominal <= r_cur;
    end
  end
endmodule
